// File: sv/sfa_pkg.sv
package sfa_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Fit policy codes.
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_NEXT  = 2'd3;

  // One table entry as held in the segment memory.
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] last;
    logic [16:0] len;
    logic [7:0]  owner;
  } seg_t;

endpackage

// File: sv/segment_fit_allocator_unit.sv
// Segment fit allocator. The segment table lives in one synchronous memory with
// a single read port and a single write port. A request first scans the table,
// one entry a cycle, then, when a split is needed, moves the tail up one entry
// at a time, each through a read state and a write state, and writes the two
// halves. An invalid (zero size) request goes straight to the output state.
// After reset the table is loaded with one free segment covering all of memory;
// no clearing pass is needed.
module segment_fit_allocator_unit #(
  parameter int MAP_ENTRIES = 32,
  parameter int MEM_WORDS   = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_fit_policy,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [16:0] in_request_size,
  input  logic [7:0]  in_owner_id,
  input  logic [15:0] in_next_fit_from,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_seg_start,
  output logic [15:0] out_seg_end,
  output logic [16:0] out_seg_size,
  output logic [7:0]  out_seg_owner
);

  localparam int IW = $clog2(MAP_ENTRIES);
  localparam int CW = $clog2(MAP_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAP_ENTRIES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_SHRD  = 3'd3;
  localparam logic [2:0] S_SHWR  = 3'd4;
  localparam logic [2:0] S_SPLIT = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // Segment memory.
  sfa_pkg::seg_t mem [MAP_ENTRIES];
  sfa_pkg::seg_t rd_q;
  logic [IW-1:0] rd_addr;
  logic          rd_en;
  logic [IW-1:0] wr_addr;
  logic          wr_en;
  sfa_pkg::seg_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    pol_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          init_r;
  logic [16:0]   req_r;
  logic [7:0]    own_r;
  logic [15:0]   from_r;
  logic [CW-1:0] idx_r, idx_nxt;     // next address to read
  logic [CW-1:0] cur_r, cur_nxt;     // address of the data in rd_q
  logic          rv_r, rv_nxt;       // rd_q holds a scanned entry
  logic          found_r, found_nxt;
  logic [IW-1:0] pick_r, pick_nxt;
  sfa_pkg::seg_t pseg_r, pseg_nxt;
  logic [1:0]    ost_r, ost_nxt;
  sfa_pkg::seg_t oseg_r, oseg_nxt;

  // Candidate test on the entry just read.
  logic fits, exact, better;
  always_comb begin
    fits = (rd_q.owner == 8'd0) && (rd_q.len >= req_r) &&
           !((pol_r == sfa_pkg::POL_NEXT) && (rd_q.start < from_r));
    exact = fits && (rd_q.len == req_r);
    better = !found_r ||
             ((pol_r == sfa_pkg::POL_BEST) && (rd_q.len < pseg_r.len)) ||
             ((pol_r == sfa_pkg::POL_WORST) && (rd_q.len > pseg_r.len));
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    cur_nxt   = cur_r;
    rv_nxt    = 1'b0;
    found_nxt = found_r;
    pick_nxt  = pick_r;
    pseg_nxt  = pseg_r;
    ost_nxt   = ost_r;
    oseg_nxt  = oseg_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r[IW-1:0];
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    if (init_r) begin
      wr_en   = 1'b1;
      wr_data = '{start: 16'd0, last: 16'(MEM_WORDS - 1), len: 17'(MEM_WORDS),
                  owner: 8'd0};
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !init_r) begin
          found_nxt = 1'b0;
          idx_nxt   = '0;
          if (in_request_size == 17'd0) begin
            ost_nxt   = sfa_pkg::ST_INVALID;
            oseg_nxt  = '0;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Issue the next read while testing the previous one.
        if (rv_r && fits && exact) begin
          wr_en     = 1'b1;
          wr_addr   = cur_r[IW-1:0];
          wr_data   = rd_q;
          wr_data.owner = own_r;
          pick_nxt  = cur_r[IW-1:0];
          ost_nxt   = sfa_pkg::ST_OK;
          oseg_nxt  = wr_data;
          state_nxt = S_OUT;
        end else if (rv_r && fits && found_r == 1'b0 &&
                     (pol_r == sfa_pkg::POL_FIRST || pol_r == sfa_pkg::POL_NEXT)) begin
          found_nxt = 1'b1;
          pick_nxt  = cur_r[IW-1:0];
          pseg_nxt  = rd_q;
          state_nxt = S_DEC;
        end else begin
          if (rv_r && fits && better) begin
            found_nxt = 1'b1;
            pick_nxt  = cur_r[IW-1:0];
            pseg_nxt  = rd_q;
          end
          if (idx_r < cnt_r) begin
            rd_en   = 1'b1;
            rv_nxt  = 1'b1;
            cur_nxt = idx_r;
            idx_nxt = idx_r + 1'b1;
          end else begin
            state_nxt = S_DEC;
          end
        end
      end
      S_DEC: begin
        oseg_nxt = '0;
        if (!found_r) begin
          ost_nxt   = sfa_pkg::ST_NOFIT;
          state_nxt = S_OUT;
        end else if (cnt_r >= FULL_CNT) begin
          ost_nxt   = sfa_pkg::ST_FULL;
          state_nxt = S_OUT;
        end else begin
          idx_nxt   = cnt_r;
          state_nxt = S_SHRD;
        end
      end
      S_SHRD: begin
        // idx_r is the destination; move entry idx_r-1 up.
        if (idx_r > CW'(pick_r) + 1'b1) begin
          rd_en     = 1'b1;
          rd_addr   = IW'(idx_r - 1'b1);
          state_nxt = S_SHWR;
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_SHWR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r[IW-1:0];
        wr_data   = rd_q;
        idx_nxt   = idx_r - 1'b1;
        state_nxt = S_SHRD;
      end
      S_SPLIT: begin
        // Free remainder now; allocated head written in the output state.
        wr_en     = 1'b1;
        wr_addr   = IW'(CW'(pick_r) + 1'b1);
        wr_data   = '{start: pseg_r.start + req_r[15:0], last: pseg_r.last,
                      len: pseg_r.len - req_r, owner: 8'd0};
        oseg_nxt  = '{start: pseg_r.start,
                      last: pseg_r.start + req_r[15:0] - 16'd1,
                      len: req_r, owner: own_r};
        ost_nxt   = sfa_pkg::ST_OK;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (ost_r == sfa_pkg::ST_OK && !init_r) begin
          wr_en   = 1'b1;
          wr_addr = pick_r;
          wr_data = oseg_r;
        end
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pol_r   <= sfa_pkg::POL_FIRST;
      cnt_r   <= CW'(1);
      init_r  <= 1'b1;
      rv_r    <= 1'b0;
      found_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      init_r  <= 1'b0;
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rv_r    <= rv_nxt;
      found_r <= found_nxt;
      idx_r   <= idx_nxt;
      if (cfg_we) begin
        pol_r <= cfg_fit_policy;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    pick_r <= pick_nxt;
    pseg_r <= pseg_nxt;
    ost_r  <= ost_nxt;
    oseg_r <= oseg_nxt;
    if (state_r == S_IDLE && in_valid) begin
      req_r  <= in_request_size;
      own_r  <= in_owner_id;
      from_r <= in_next_fit_from;
    end
  end

  // For an exact fit the pick is the entry just rewritten.
  always_comb begin
    in_ready      = (state_r == S_IDLE) && !init_r;
    out_valid     = (state_r == S_OUT);
    out_status    = ost_r;
    out_seg_start = oseg_r.start;
    out_seg_end   = oseg_r.last;
    out_seg_size  = oseg_r.len;
    out_seg_owner = oseg_r.owner;
  end

  // The table never grows past its depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT) else $error("segment count overflow");
  // A split grows the table by exactly one.
  a_split_grow: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SPLIT |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("split did not grow table");
  // A non-OK result carries zero fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sfa_pkg::ST_OK |-> oseg_r == '0)
    else $error("fields set on failed request");

endmodule
